### design/mmcpu_pkg.sv
// ----------------------------------------------------------------------------
// mmcpu_pkg
// Shared constants and ALU/branch functions for the memory-to-memory processor step block.
// ----------------------------------------------------------------------------
package mmcpu_pkg;

	// host request codes
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_EXEC  = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	// base operations
	localparam logic [3:0] OP_MIMM = 4'd0;
	localparam logic [3:0] OP_MDIR = 4'd1;
	localparam logic [3:0] OP_MIND = 4'd2;
	localparam logic [3:0] OP_AND  = 4'd3;
	localparam logic [3:0] OP_OR   = 4'd4;
	localparam logic [3:0] OP_XOR  = 4'd5;
	localparam logic [3:0] OP_ADD  = 4'd6;
	localparam logic [3:0] OP_SUB  = 4'd7;
	localparam logic [3:0] OP_SHR  = 4'd8;
	localparam logic [3:0] OP_SHL  = 4'd9;
	localparam logic [3:0] OP_SAR  = 4'd10;
	localparam logic [3:0] OP_BLE  = 4'd11;
	localparam logic [3:0] OP_BGE  = 4'd12;
	localparam logic [3:0] OP_BBE  = 4'd13;
	localparam logic [3:0] OP_BAE  = 4'd14;
	localparam logic [3:0] OP_BNE  = 4'd15;

	// opcode flag bits
	localparam int OPF_BYTE = 4;
	localparam int OPF_ALT  = 5;

	// ALU and branch decision on the 16-bit operands
	function automatic logic [15:0] alu(input logic [3:0] base, input logic wide,
			input logic [15:0] d, input logic [15:0] s);
		logic [3:0]  c;
		logic [15:0] r;
		logic [15:0] sext;
		begin
			c = wide ? s[3:0] : {1'b0, s[2:0]};
			sext = wide ? d : {{8{d[7]}}, d[7:0]};
			case (base)
				OP_AND:  r = d & s;
				OP_OR:   r = d | s;
				OP_XOR:  r = d ^ s;
				OP_ADD:  r = d + s;
				OP_SUB:  r = d - s;
				OP_SHR:  r = d >> c;
				OP_SHL:  r = d << c;
				OP_SAR:  r = 16'($signed(sext) >>> c);
				default: r = s;
			endcase
			alu = r;
		end
	endfunction

	function automatic logic take(input logic [3:0] base, input logic wide,
			input logic [15:0] x, input logic [15:0] y);
		logic lts, eq, ltu;
		begin
			lts = $signed(x) < $signed(y);
			ltu = x < y;
			eq  = x == y;
			case (base)
				OP_BLE:  take = wide ? (lts | eq) : lts;
				OP_BGE:  take = wide ? !lts : (!lts & !eq);
				OP_BBE:  take = wide ? (ltu | eq) : ltu;
				OP_BAE:  take = wide ? !ltu : (!ltu & !eq);
				default: take = wide ? !eq : eq;
			endcase
		end
	endfunction

endpackage

### design/memory_to_memory_cpu_step.sv
// An unknown request, or an execute while halted, only reads back the ip word.
// One transaction in flight; the next is accepted in the cycle after the
// result leaves. Every byte goes through the one memory port, whose read
// data is registered.
// Reset clears the halt flag and control; memory contents stay undefined.
// ----------------------------------------------------------------------------
// memory_to_memory_cpu_step
// Memory-to-memory processor: host byte access and single-instruction step.
// ----------------------------------------------------------------------------
module memory_to_memory_cpu_step #(
	parameter int MEM_BYTES = 65536,
	parameter int IP_ADDR   = 0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [15:0] addr,
	input  logic [7:0]  wdata,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  rdata,
	output logic [15:0] ip_now,
	output logic        halted
);
	// MEM_BYTES is a power of two: the low address bits select the byte
	localparam int AW = $clog2(MEM_BYTES);

	typedef enum logic [3:0] {
		S_IDLE, S_HWR, S_HRD, S_IP, S_INS, S_ARG, S_IPW, S_LBL, S_PTR, S_SRC,
		S_DPTR, S_DST, S_WB, S_IPRD, S_OUT
	} state_t;

	state_t      st_q;
	logic        halt_q;
	logic [15:0] haddr_q;
	logic [7:0]  hdata_q;
	logic [7:0]  rdata_q;
	logic [15:0] ipn_q;
	// byte counter within a word access, low byte of a word read
	logic [1:0]  bc_q;
	logic [7:0]  lo_q;
	logic [15:0] ip_q, w_q, a1_q, lbl_q, src_q, s_q, dst_q, wv_q;

	logic        m_we;
	logic [15:0] m_a;
	logic [7:0]  m_wd, m_rd;

	mmcpu_mem #(.MEM_BYTES(MEM_BYTES)) u_mem (
		.clk(clk), .we(m_we), .a(m_a[AW-1:0]), .wd(m_wd), .rd(m_rd)
	);

	// instruction decode
	logic [3:0]  base;
	logic        wide, alt;
	logic [15:0] reg16;
	assign base  = w_q[13:10];
	assign wide  = !w_q[10+mmcpu_pkg::OPF_BYTE];
	assign alt   = w_q[10+mmcpu_pkg::OPF_ALT];
	assign reg16 = {6'd0, w_q[9:0]};

	logic is_mov, is_shift, is_br, is_halt, wtwo;
	assign is_mov   = base inside {[mmcpu_pkg::OP_MIMM:mmcpu_pkg::OP_MIND]};
	assign is_shift = base inside {[mmcpu_pkg::OP_SHR:mmcpu_pkg::OP_SAR]};
	assign is_br    = base inside {[mmcpu_pkg::OP_BLE:mmcpu_pkg::OP_BNE]};
	assign is_halt  = base == mmcpu_pkg::OP_MIMM && !wide && !alt
		&& w_q[9:0] == 10'd0 && a1_q == 16'd0;
	// branches write the ip word back through the result write
	assign wtwo     = wide || is_br;

	// read helper: byte reads or two-byte word reads
	logic [15:0] rb, rval, ip4;
	logic        rbyte, rdone;
	assign ip4   = ip_q + 16'd4;
	assign rval  = rbyte ? {8'd0, m_rd} : {m_rd, lo_q};
	assign rdone = rbyte ? bc_q == 2'd1 : bc_q == 2'd2;

	// read base address and width per state
	always_comb begin
		rb    = 16'd0;
		rbyte = 1'b0;
		case (st_q)
			S_HRD: begin
				rb    = haddr_q;
				rbyte = 1'b1;
			end
			S_IP, S_IPRD: rb = 16'(IP_ADDR);
			S_INS:  rb = ip_q;
			S_ARG:  rb = ip_q + 16'd2;
			S_LBL:  rb = ip4;
			S_PTR:  rb = a1_q;
			S_SRC: begin
				rb    = src_q;
				rbyte = !is_br && (is_shift || !wide);
			end
			S_DPTR: rb = reg16;
			S_DST: begin
				rb    = reg16;
				rbyte = !is_br && !wide;
			end
			default: ;
		endcase
	end

	// memory port address and write selection
	always_comb begin
		m_we = 1'b0;
		m_wd = 8'd0;
		m_a  = rb + {15'd0, bc_q[0]};
		case (st_q)
			S_HWR: begin
				m_a  = haddr_q;
				m_we = 1'b1;
				m_wd = hdata_q;
			end
			S_IPW: begin
				m_a  = 16'(IP_ADDR) + {15'd0, bc_q[0]};
				m_we = 1'b1;
				m_wd = bc_q[0] ? ip4[15:8] : ip4[7:0];
			end
			S_WB: begin
				m_a  = dst_q + {15'd0, bc_q[0]};
				m_we = 1'b1;
				m_wd = bc_q[0] ? wv_q[15:8] : wv_q[7:0];
			end
			default: ;
		endcase
	end

	logic [15:0] alu_r;
	assign alu_r = mmcpu_pkg::alu(base, wide, rval, s_q);

	// sequencer: host byte access, fetch, ip+4 write, operand reads, result write, ip read-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			halt_q  <= 1'b0;
			bc_q    <= 2'd0;
			haddr_q <= 16'd0;
			hdata_q <= 8'd0;
			rdata_q <= 8'd0;
			ipn_q   <= 16'd0;
			lo_q    <= 8'd0;
			ip_q    <= 16'd0;
			w_q     <= 16'd0;
			a1_q    <= 16'd0;
			lbl_q   <= 16'd0;
			src_q   <= 16'd0;
			s_q     <= 16'd0;
			dst_q   <= 16'd0;
			wv_q    <= 16'd0;
		end else begin
			// low byte of a word read arrives in the cycle after its address
			if (bc_q == 2'd1)
				lo_q <= m_rd;
			case (st_q)
				S_IDLE: if (in_valid) begin
					haddr_q <= addr;
					hdata_q <= wdata;
					rdata_q <= 8'd0;
					bc_q    <= 2'd0;
					case (req_type)
						mmcpu_pkg::REQ_WRITE: st_q <= S_HWR;
						mmcpu_pkg::REQ_READ:  st_q <= S_HRD;
						mmcpu_pkg::REQ_EXEC:  st_q <= halt_q ? S_IPRD : S_IP;
						default:              st_q <= S_IPRD;
					endcase
				end
				S_HWR: st_q <= S_IPRD;
				S_IPW: if (bc_q == 2'd0) begin
					bc_q <= 2'd1;
				end else begin
					bc_q  <= 2'd0;
					src_q <= a1_q;
					s_q   <= a1_q;
					wv_q  <= a1_q;
					dst_q <= reg16;
					if (is_halt) begin
						halt_q <= 1'b1;
						st_q   <= S_IPRD;
					end else if (is_br)
						st_q <= S_LBL;
					else if (base == mmcpu_pkg::OP_MIND)
						st_q <= S_PTR;
					else if (base == mmcpu_pkg::OP_MIMM)
						st_q <= alt ? S_DPTR : S_WB;
					else if (alt && !is_mov)
						st_q <= S_DST;
					else
						st_q <= S_SRC;
				end
				S_WB: if (bc_q == 2'd0 && wtwo) begin
					bc_q <= 2'd1;
				end else begin
					bc_q <= 2'd0;
					st_q <= S_IPRD;
				end
				S_HRD, S_IP, S_INS, S_ARG, S_LBL, S_PTR, S_SRC, S_DPTR, S_DST,
				S_IPRD: begin
					if (!rdone)
						bc_q <= bc_q + 2'd1;
					else begin
						bc_q <= 2'd0;
						case (st_q)
							S_HRD: begin
								rdata_q <= m_rd;
								st_q    <= S_IPRD;
							end
							S_IP: begin
								ip_q <= rval;
								st_q <= S_INS;
							end
							S_INS: begin
								w_q  <= rval;
								st_q <= S_ARG;
							end
							S_ARG: begin
								a1_q <= rval;
								st_q <= S_IPW;
							end
							S_LBL: begin
								lbl_q <= rval;
								st_q  <= alt ? S_DST : S_SRC;
							end
							S_PTR: begin
								src_q <= rval;
								st_q  <= S_SRC;
							end
							S_SRC: begin
								s_q  <= rval;
								wv_q <= rval;
								if (is_mov)
									st_q <= alt ? S_DPTR : S_WB;
								else
									st_q <= S_DST;
							end
							S_DPTR: begin
								dst_q <= rval;
								st_q  <= S_WB;
							end
							S_DST: begin
								if (is_br) begin
									dst_q <= 16'(IP_ADDR);
									wv_q  <= mmcpu_pkg::take(base, wide, rval, s_q)
										? lbl_q : ip_q + 16'd6;
								end else
									wv_q <= alu_r;
								st_q <= S_WB;
							end
							S_IPRD: begin
								ipn_q <= rval;
								st_q  <= S_OUT;
							end
							default: st_q <= S_IDLE;
						endcase
					end
				end
				S_OUT: if (!out_stall) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = st_q != S_IDLE;
	assign out_valid = st_q == S_OUT;
	assign rdata     = rdata_q;
	assign ip_now    = ipn_q;
	assign halted    = halt_q;

	a_one_phase: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && !in_stall)) else $error("accept while result pending");
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(halt_q) |-> halt_q) else $error("halt flag cleared");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(rdata) && $stable(ip_now)
		&& $stable(halted)) else $error("stalled result changed");
endmodule

### design/mmcpu_mem.sv
// ----------------------------------------------------------------------------
// mmcpu_mem
// Byte memory, one read or write port per cycle, read data registered.
// ----------------------------------------------------------------------------
module mmcpu_mem #(
	parameter int MEM_BYTES = 65536
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [$clog2(MEM_BYTES)-1:0] a,
	input  logic [7:0]                   wd,
	output logic [7:0]                   rd
);
	logic [7:0] mem_q [MEM_BYTES];

	// single-port synchronous RAM
	always_ff @(posedge clk) begin
		if (we)
			mem_q[a] <= wd;
		rd <= mem_q[a];
	end
endmodule
